[rtl/core/mmp_pkg.sv]
// Shared types, constants and the modular reduction step for the masked
// multiplier. No dependencies.
package mmp_pkg;

  localparam int unsigned SHARE_W = 31;
  localparam int unsigned RND_W   = 32;
  localparam int unsigned PROD_W  = 2 * SHARE_W;
  // Share sums before reduction stay below 2**65
  localparam int unsigned SUM_W   = 65;
  // Reduction walks a word padded to a multiple of the bits per stage
  localparam int unsigned RED_BITS   = 2;
  localparam int unsigned RED_W      = 66;
  localparam int unsigned RED_STAGES = RED_W / RED_BITS;
  // Product, partial sum and total stages ahead of the reduction
  localparam int unsigned PRE_STAGES = 3;
  localparam int unsigned LATENCY    = PRE_STAGES + RED_STAGES;

  localparam logic [SHARE_W-1:0] MODULUS_RESET = 31'd8380417;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MODULUS = 1'b0;

  typedef struct packed {
    logic [SHARE_W-1:0] a_share_0;
    logic [SHARE_W-1:0] a_share_1;
    logic [SHARE_W-1:0] a_share_2;
    logic [SHARE_W-1:0] b_share_0;
    logic [SHARE_W-1:0] b_share_1;
    logic [SHARE_W-1:0] b_share_2;
    logic [RND_W-1:0]   rnd_pair_01;
    logic [RND_W-1:0]   rnd_pair_02;
    logic [RND_W-1:0]   rnd_pair_12;
  } op_t;

  typedef struct packed {
    logic [SHARE_W-1:0] c_share_0;
    logic [SHARE_W-1:0] c_share_1;
    logic [SHARE_W-1:0] c_share_2;
  } res_t;

  // One restoring step: shift in one bit, subtract p when it fits
  function automatic logic [SHARE_W-1:0] red_step(input logic [SHARE_W-1:0] rem,
                                                  input logic             bit_in,
                                                  input logic [SHARE_W-1:0] p);
    logic [SHARE_W:0] sh;
    logic [SHARE_W:0] diff;
    sh   = {rem, bit_in};
    diff = sh - {1'b0, p};
    if (sh >= {1'b0, p}) begin
      red_step = diff[SHARE_W-1:0];
    end else begin
      red_step = sh[SHARE_W-1:0];
    end
  endfunction

endpackage

[rtl/core/mmp_products.sv]
// Product, partial sum and total stages: forms each output share as one
// non-negative sum congruent to it mod p. Uses mmp_pkg.
module mmp_products (
  input  logic                          clk,
  input  logic                          en,
  input  mmp_pkg::op_t                  op,
  input  logic [mmp_pkg::SHARE_W-1:0]   modulus,
  output logic [mmp_pkg::SUM_W-1:0]     total_0,
  output logic [mmp_pkg::SUM_W-1:0]     total_1,
  output logic [mmp_pkg::SUM_W-1:0]     total_2
);

  localparam int unsigned PW = mmp_pkg::PROD_W;
  localparam int unsigned SW = mmp_pkg::SUM_W;
  localparam int unsigned RW = mmp_pkg::RND_W;

  // Stage 1: the nine share products, random words and multiples of p
  logic [PW-1:0] p00, p11, p22, p01, p10, p02, p20, p12, p21;
  logic [RW-1:0] r01, r02, r12;
  logic [SW-1:0] p_sh33;   // p * 2**33, absorbs the two subtractions on share 0
  logic [SW-1:0] p_r12;    // p * 2**32 - r12

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= PW'(op.a_share_0) * PW'(op.b_share_0);
      p11 <= PW'(op.a_share_1) * PW'(op.b_share_1);
      p22 <= PW'(op.a_share_2) * PW'(op.b_share_2);
      p01 <= PW'(op.a_share_0) * PW'(op.b_share_1);
      p10 <= PW'(op.a_share_1) * PW'(op.b_share_0);
      p02 <= PW'(op.a_share_0) * PW'(op.b_share_2);
      p20 <= PW'(op.a_share_2) * PW'(op.b_share_0);
      p12 <= PW'(op.a_share_1) * PW'(op.b_share_2);
      p21 <= PW'(op.a_share_2) * PW'(op.b_share_1);
      r01 <= op.rnd_pair_01;
      r02 <= op.rnd_pair_02;
      r12 <= op.rnd_pair_12;
      p_sh33 <= {1'b0, modulus, 33'd0};
      p_r12  <= {2'b0, modulus, 32'd0} - SW'(op.rnd_pair_12);
    end
  end

  // Stage 2: partial sums
  logic [SW-1:0] s0a, s0b, s1a, s1b, s2a, s2b;

  always_ff @(posedge clk) begin
    if (en) begin
      s0a <= SW'(p00) + p_sh33;
      s0b <= SW'(r01) + SW'(r02);
      s1a <= SW'(p11) + SW'(p01);
      s1b <= SW'(p10) + SW'(r01) + p_r12;
      s2a <= SW'(p22) + SW'(p02) + SW'(p20);
      s2b <= SW'(p12) + SW'(p21) + SW'(r02) + SW'(r12);
    end
  end

  // Stage 3: totals
  always_ff @(posedge clk) begin
    if (en) begin
      total_0 <= s0a - s0b;
      total_1 <= s1a + s1b;
      total_2 <= s2a + s2b;
    end
  end

endmodule

[rtl/core/mmp_reduce.sv]
// Pipelined restoring reduction of one share sum mod p, a fixed number of
// bits per stage. Uses mmp_pkg.
module mmp_reduce (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mmp_pkg::SUM_W-1:0]     total,
  input  logic [mmp_pkg::SHARE_W-1:0]   modulus,
  output logic [mmp_pkg::SHARE_W-1:0]   rem
);

  localparam int unsigned NS = mmp_pkg::RED_STAGES;
  localparam int unsigned VW = mmp_pkg::RED_W;
  localparam int unsigned NB = mmp_pkg::RED_BITS;
  localparam int unsigned HW = mmp_pkg::SHARE_W;

  logic [HW-1:0] rem_q [NS];
  logic [VW-1:0] val_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [HW-1:0] rem_in;
    logic [VW-1:0] val_in;
    logic [HW-1:0] rem_next;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign val_in = VW'(total);
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign val_in = val_q[k-1];
    end

    // Top bits of the remaining word, most significant first
    always_comb begin
      rem_next = rem_in;
      for (int s = 0; s < NB; s++) begin
        rem_next = mmp_pkg::red_step(rem_next, val_in[VW-1-s], modulus);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_next;
        val_q[k] <= val_in << NB;
      end
    end
  end

  assign rem = rem_q[NS-1];

endmodule

[rtl/core/masked_multiply_mod_p.sv]
// Top level of the three-share masked multiplier mod p.
// Uses mmp_pkg, mmp_products and mmp_reduce.
//
// Takes one operand word per clock and returns one result word per clock
// unless res_stall holds a finished result: three stages form the nine
// share products and sum them, then 33 stages reduce each share
// sum mod p two bits at a time. The whole pipeline holds while a finished
// result waits under res_stall. The modulus (register 0, byte address 0,
// reset 8380417) must only be written while the pipeline is empty; a
// modulus of zero gives all-zero result shares.
module masked_multiply_mod_p (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmp_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          op_valid,
  output logic                          op_stall,
  input  mmp_pkg::op_t                  op,
  output logic                          res_valid,
  input  logic                          res_stall,
  output mmp_pkg::res_t                 res
);

  localparam int unsigned LAT = mmp_pkg::LATENCY;
  localparam int unsigned HW  = mmp_pkg::SHARE_W;

  // Configuration register
  logic [HW-1:0] modulus;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mmp_pkg::MODULUS_RESET;
    end else if (psel && penable && pwrite && reg_sel == mmp_pkg::REG_MODULUS) begin
      modulus <= pwdata[HW-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      mmp_pkg::REG_MODULUS: prdata = {1'b0, modulus};
      default:              prdata = '0;
    endcase
  end

  // Global advance: everything moves unless a result word is held
  logic en;
  logic [LAT-1:0] vld;

  assign en       = !(vld[LAT-1] && res_stall);
  assign op_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], op_valid};
    end
  end

  // Datapath
  logic [mmp_pkg::SUM_W-1:0] total_0, total_1, total_2;
  logic [HW-1:0] rem_0, rem_1, rem_2;

  mmp_products u_products (
    .clk     (clk),
    .en      (en),
    .op      (op),
    .modulus (modulus),
    .total_0 (total_0),
    .total_1 (total_1),
    .total_2 (total_2)
  );

  mmp_reduce u_reduce_0 (.clk(clk), .en(en), .total(total_0), .modulus(modulus), .rem(rem_0));
  mmp_reduce u_reduce_1 (.clk(clk), .en(en), .total(total_1), .modulus(modulus), .rem(rem_1));
  mmp_reduce u_reduce_2 (.clk(clk), .en(en), .total(total_2), .modulus(modulus), .rem(rem_2));

  // Result word; zero modulus forces zero shares
  logic p_zero;
  assign p_zero    = (modulus == '0);
  assign res_valid = vld[LAT-1];
  assign res.c_share_0 = p_zero ? '0 : rem_0;
  assign res.c_share_1 = p_zero ? '0 : rem_1;
  assign res.c_share_2 = p_zero ? '0 : rem_2;

endmodule
